@@ design/acal_pkg.sv @@
// Shared types and constants for the accelerometer offset auto-calibrator.
// Used by acal_lane and accel_offset_autocalibrator_top; depends on nothing.
package acal_pkg;

  // Field and accumulator widths
  localparam int SAMPLE_W   = 16;
  localparam int SETTLE_W   = 10;
  localparam int AVERAGE_W  = 11;
  localparam int DEADZONE_W = 15;
  localparam int INDEX_W    = 11;
  // Up to 2047 summed 16-bit samples need 27 signed bits.
  localparam int SUM_W      = 27;
  localparam int CNT_W      = $clog2(SUM_W);
  localparam int NUM_AXES   = 3;

  localparam int MAX_AVERAGE = 1024;

  // Register reset values
  localparam logic [SETTLE_W-1:0]   SETTLE_RESET   = SETTLE_W'(101);
  localparam logic [AVERAGE_W-1:0]  AVERAGE_RESET  = AVERAGE_W'(100);
  localparam logic [DEADZONE_W-1:0] DEADZONE_RESET = DEADZONE_W'(10);

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_SETTLE   = 2'd0,
    REG_AVERAGE  = 2'd1,
    REG_DEADZONE = 2'd2
  } reg_idx_t;

  // Calibration phase
  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_LATER = 2'd1,
    PH_DONE  = 2'd2
  } phase_t;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_EMIT = 2'd2
  } state_t;

  // What one lane reports to the merging stage
  typedef struct packed {
    logic                done;
    logic                in_zone;
    logic [SAMPLE_W-1:0] offset;
  } lane_res_t;

endpackage

@@ design/acal_lane.sv @@
// One axis lane: divides the pass sum by the average count one quotient bit
// per cycle, saturates the mean and decides the offset update. Uses acal_pkg.
module acal_lane import acal_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [SUM_W-1:0]      sum,
  input  logic        [AVERAGE_W-1:0]  divisor,
  input  logic        [DEADZONE_W-1:0] deadzone,
  input  logic        [SAMPLE_W-1:0]   offset,
  input  logic                         first,
  output lane_res_t                    res
);

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [SUM_W-1:0]     quo_r;
  logic [AVERAGE_W-1:0] rem_r;
  logic [AVERAGE_W-1:0] div_r;
  logic                 neg_r;

  logic [AVERAGE_W:0]   trial;
  logic                 fits;
  logic [SAMPLE_W-1:0]  mean;
  logic [SAMPLE_W-1:0]  mag;
  logic                 in_zone;
  logic                 update;

  // Restoring division step on the magnitude
  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign fits  = trial >= {1'b0, div_r};

  // Control of the iteration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Quotient and remainder shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= sum[SUM_W-1];
      quo_r <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[SUM_W-2:0], fits};
      rem_r <= fits ? AVERAGE_W'(trial - {1'b0, div_r}) : trial[AVERAGE_W-1:0];
    end
  end

  // Saturate the mean to 16 bits and take its magnitude
  always_comb begin
    if (neg_r) begin
      if (quo_r >= SUM_W'(32768)) begin
        mean = 16'h8000;
        mag  = 16'h8000;
      end else begin
        mean = SAMPLE_W'(-quo_r[SAMPLE_W-1:0]);
        mag  = quo_r[SAMPLE_W-1:0];
      end
    end else begin
      if (quo_r > SUM_W'(32767)) begin
        mean = 16'h7FFF;
        mag  = 16'h7FFF;
      end else begin
        mean = quo_r[SAMPLE_W-1:0];
        mag  = quo_r[SAMPLE_W-1:0];
      end
    end
  end

  // Offset decision
  assign in_zone = mag <= {1'b0, deadzone};
  assign update  = first || !in_zone;

  assign res.done    = done_r;
  assign res.in_zone = in_zone;
  assign res.offset  = update ? SAMPLE_W'(offset - mean) : offset;

endmodule

@@ design/accel_offset_autocalibrator_top.sv @@
// Accelerometer offset auto-calibrator, top level. Instantiates three acal_lane.
// An ordinary item's result passes through the pending result registers into the
// output register; an item that closes a pass first waits for the 27-step divider.
// A new item is taken only once the last one's result has entered the output register.
// Reset (rst_n, synchronous): first pass, zero sums, index and offsets, and
// registers at 101, 100 and 10.
module accel_offset_autocalibrator_top import acal_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [14:0] cfg_wdata,
  // Input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // raw_x, raw_y, raw_z
  // Result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // cal_x, cal_y, cal_z, offset_x, offset_y, offset_z
  output logic        out_tlast,  // pass_end
  output logic        out_tuser   // calibrated
);

  logic [SETTLE_W-1:0]   settle_r;
  logic [AVERAGE_W-1:0]  average_r;
  logic [DEADZONE_W-1:0] deadzone_r;

  phase_t                     phase_r;
  phase_t                     phase_nxt;
  state_t                     st_r;
  state_t                     st_nxt;
  logic [INDEX_W-1:0]         index_r;
  logic signed [SUM_W-1:0]    sum_r     [NUM_AXES];
  logic [SAMPLE_W-1:0]        offset_r  [NUM_AXES];

  // Pending result and output register
  logic [SAMPLE_W-1:0]        res_cal_r [NUM_AXES];
  logic [SAMPLE_W-1:0]        res_off_r [NUM_AXES];
  logic                       res_last_r;
  logic                       res_done_r;
  logic                       out_valid_r;
  logic [95:0]                out_data_r;
  logic                       out_last_r;
  logic                       out_user_r;

  logic [SAMPLE_W-1:0]        cal       [NUM_AXES];
  logic signed [SUM_W-1:0]    sum_add   [NUM_AXES];
  lane_res_t                  lane_res  [NUM_AXES];
  logic [AVERAGE_W-1:0]       avg_eff;
  logic [INDEX_W:0]           last_idx;
  logic                       accept;
  logic                       active;
  logic                       summed;
  logic                       close;
  logic                       all_within;
  logic                       slot_free;
  logic                       lanes_done;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r   <= SETTLE_RESET;
      average_r  <= AVERAGE_RESET;
      deadzone_r <= DEADZONE_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SETTLE:   settle_r   <= cfg_wdata[SETTLE_W-1:0];
        REG_AVERAGE:  average_r  <= cfg_wdata[AVERAGE_W-1:0];
        REG_DEADZONE: deadzone_r <= cfg_wdata[DEADZONE_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective average count and the index that closes the pass
  always_comb begin
    if (average_r == '0) begin
      avg_eff = AVERAGE_W'(1);
    end else if (average_r > AVERAGE_W'(MAX_AVERAGE)) begin
      avg_eff = AVERAGE_W'(MAX_AVERAGE);
    end else begin
      avg_eff = average_r;
    end
  end

  assign last_idx = (INDEX_W+1)'(settle_r) + (INDEX_W+1)'(avg_eff) - (INDEX_W+1)'(1);
  assign accept   = in_tvalid && in_tready;
  assign active   = phase_r != PH_DONE;
  assign summed   = index_r >= INDEX_W'(settle_r);
  assign close    = active && ({1'b0, index_r} >= last_idx);

  // Correction and running sums per axis
  for (genvar k = 0; k < NUM_AXES; k++) begin : g_axis
    assign cal[k]     = in_tdata[k*SAMPLE_W +: SAMPLE_W] + offset_r[k];
    assign sum_add[k] = sum_r[k] + SUM_W'($signed(cal[k]));

    acal_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (accept && close),
      .sum      (sum_add[k]),
      .divisor  (avg_eff),
      .deadzone (deadzone_r),
      .offset   (offset_r[k]),
      .first    (phase_r == PH_FIRST),
      .res      (lane_res[k])
    );
  end

  // Merging stage inputs
  assign lanes_done = lane_res[0].done && lane_res[1].done && lane_res[2].done;
  assign all_within = lane_res[0].in_zone && lane_res[1].in_zone && lane_res[2].in_zone;
  assign slot_free  = !out_valid_r || out_tready;

  // Sequencer next state and phase update
  always_comb begin
    st_nxt    = st_r;
    phase_nxt = phase_r;
    in_tready = 1'b0;
    case (st_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          st_nxt = close ? ST_DIV : ST_EMIT;
        end
      end
      ST_DIV: begin
        if (lanes_done) begin
          st_nxt = ST_EMIT;
          if (phase_r == PH_FIRST) begin
            phase_nxt = PH_LATER;
          end else if (all_within) begin
            phase_nxt = PH_DONE;
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      phase_r <= PH_FIRST;
      index_r <= '0;
    end else begin
      st_r    <= st_nxt;
      phase_r <= phase_nxt;
      if (accept && active) begin
        index_r <= close ? '0 : index_r + INDEX_W'(1);
      end
    end
  end

  // Sums and offsets
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        sum_r[k]    <= '0;
        offset_r[k] <= '0;
      end
    end else begin
      for (int k = 0; k < NUM_AXES; k++) begin
        if (accept && active) begin
          if (close) begin
            sum_r[k] <= '0;
          end else if (summed) begin
            sum_r[k] <= sum_add[k];
          end
        end
        if (st_r == ST_DIV && lanes_done) begin
          offset_r[k] <= lane_res[k].offset;
        end
      end
    end
  end

  // Pending result for the item at work
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        res_cal_r[k] <= cal[k];
        res_off_r[k] <= offset_r[k];
      end
      res_last_r <= 1'b0;
      res_done_r <= !active;
    end else if (st_r == ST_DIV && lanes_done) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        res_off_r[k] <= lane_res[k].offset;
      end
      res_last_r <= 1'b1;
      res_done_r <= phase_nxt == PH_DONE;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (st_r == ST_EMIT && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_EMIT && slot_free) begin
      out_data_r <= {res_off_r[2], res_off_r[1], res_off_r[0],
                     res_cal_r[2], res_cal_r[1], res_cal_r[0]};
      out_last_r <= res_last_r;
      out_user_r <= res_done_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

endmodule

@@ test/acal_checker.sv @@
// Result checker for the accelerometer offset auto-calibrator testbench.
// Tracks the calibration state from the accepted input items and register writes,
// and compares every result item with its prediction. Depends on acal_pkg.
module acal_checker import acal_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [14:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,   // raw_x, raw_y, raw_z
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [95:0] out_tdata,  // cal_x, cal_y, cal_z, offset_x, offset_y, offset_z
  input  logic        out_tlast,  // pass_end
  input  logic        out_tuser,  // calibrated
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  // One result item, laid out as {out_tuser, out_tlast, out_tdata}
  typedef struct packed {
    logic                               calibrated;
    logic                               pass_end;
    logic [NUM_AXES-1:0][SAMPLE_W-1:0]  offset;
    logic [NUM_AXES-1:0][SAMPLE_W-1:0]  cal;
  } sample_res_t;

  // Register copies and calibration state
  logic [SETTLE_W-1:0]   settle_q;
  logic [AVERAGE_W-1:0]  average_q;
  logic [DEADZONE_W-1:0] deadzone_q;
  phase_t                phase_q;
  int unsigned           index_q;
  longint                axis_sum_q [NUM_AXES];
  logic [SAMPLE_W-1:0]   axis_offset_q [NUM_AXES];

  sample_res_t           expected_results[$];

  // Count a failure and report the first few of them.
  function automatic void flag_error(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endfunction

  // Correct one raw sample, advance the pass bookkeeping and queue the result.
  task automatic track_sample(input logic [NUM_AXES-1:0][SAMPLE_W-1:0] raw);
    sample_res_t res;
    int unsigned avg;
    int unsigned last_idx;
    int          settled;
    longint      mean;
    longint      mag;
    int          k;
    res = '0;
    for (k = 0; k < NUM_AXES; k++) begin
      res.cal[k] = raw[k] + axis_offset_q[k];
    end
    if (phase_q != PH_DONE) begin
      // A zero count acts as one, and the count is capped.
      avg = (average_q == '0) ? 1 : average_q;
      if (avg > MAX_AVERAGE) begin
        avg = MAX_AVERAGE;
      end
      last_idx = settle_q + avg - 1;
      if (index_q >= settle_q) begin
        for (k = 0; k < NUM_AXES; k++) begin
          axis_sum_q[k] += longint'($signed(res.cal[k]));
        end
      end
      if (index_q >= last_idx) begin
        res.pass_end = 1'b1;
        settled = 0;
        for (k = 0; k < NUM_AXES; k++) begin
          // Mean truncates toward zero and saturates to the sample range.
          mean = axis_sum_q[k] / longint'(avg);
          if (mean > 32767) begin
            mean = 32767;
          end
          if (mean < -32768) begin
            mean = -32768;
          end
          mag = (mean < 0) ? -mean : mean;
          if (phase_q == PH_FIRST || mag > longint'(deadzone_q)) begin
            axis_offset_q[k] = axis_offset_q[k] - mean[SAMPLE_W-1:0];
          end else begin
            settled++;
          end
          axis_sum_q[k] = 0;
        end
        index_q = 0;
        if (phase_q == PH_FIRST) begin
          phase_q = PH_LATER;
        end else if (settled == NUM_AXES) begin
          phase_q = PH_DONE;
        end
      end else begin
        index_q++;
      end
    end
    for (k = 0; k < NUM_AXES; k++) begin
      res.offset[k] = axis_offset_q[k];
    end
    res.calibrated = (phase_q == PH_DONE);
    expected_results.push_back(res);
  endtask

  // Field by field comparison of one result item.
  task automatic compare_result(input sample_res_t want, input sample_res_t got);
    int k;
    for (k = 0; k < NUM_AXES; k++) begin
      if (got.cal[k] !== want.cal[k]) begin
        flag_error($sformatf("cal[%0d] mismatch: expected 0x%04h, got 0x%04h",
                             k, want.cal[k], got.cal[k]));
      end
      if (got.offset[k] !== want.offset[k]) begin
        flag_error($sformatf("offset[%0d] mismatch: expected 0x%04h, got 0x%04h",
                             k, want.offset[k], got.offset[k]));
      end
    end
    if (got.pass_end !== want.pass_end) begin
      flag_error($sformatf("pass_end mismatch: expected %b, got %b",
                           want.pass_end, got.pass_end));
    end
    if (got.calibrated !== want.calibrated) begin
      flag_error($sformatf("calibrated mismatch: expected %b, got %b",
                           want.calibrated, got.calibrated));
    end
  endtask

  // Everything is sampled at the rising edge, in the order writes, results, items.
  always @(posedge clk) begin
    sample_res_t want;
    int          k;
    if (!rst_n) begin
      settle_q   = SETTLE_RESET;
      average_q  = AVERAGE_RESET;
      deadzone_q = DEADZONE_RESET;
      phase_q    = PH_FIRST;
      index_q    = 0;
      for (k = 0; k < NUM_AXES; k++) begin
        axis_sum_q[k]    = 0;
        axis_offset_q[k] = '0;
      end
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_addr))
          REG_SETTLE:   settle_q   = cfg_wdata[SETTLE_W-1:0];
          REG_AVERAGE:  average_q  = cfg_wdata[AVERAGE_W-1:0];
          REG_DEADZONE: deadzone_q = cfg_wdata[DEADZONE_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          flag_error($sformatf("unexpected result item 0x%h", out_tdata));
        end else begin
          want = expected_results.pop_front();
          compare_result(want, sample_res_t'({out_tuser, out_tlast, out_tdata}));
        end
      end
      if (in_tvalid && in_tready) begin
        track_sample(in_tdata);
      end
    end
    pending = expected_results.size();
  end

endmodule

@@ test/tb_accel_offset_autocalibrator_top.sv @@
// Testbench top for accel_offset_autocalibrator_top: clock, reset, register
// writes, sample stimulus and output back-pressure; checking is done by
// acal_checker. Depends on acal_pkg and the block's RTL.
module tb_accel_offset_autocalibrator_top;
  timeunit 1ns;
  timeprecision 1ps;
  import acal_pkg::*;

  localparam int ITEM_TARGET    = 1100;
  localparam int LATE_START     = 850;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 40;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_addr   = REG_SETTLE;
  logic [14:0] cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;   // raw_x, raw_y, raw_z
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;         // cal_x, cal_y, cal_z, offset_x, offset_y, offset_z
  logic        out_tlast;         // pass_end
  logic        out_tuser;         // calibrated
  int          fail_count;
  int          pending;

  // Sender burst state
  int unsigned burst_left = 0;
  bit          gaps_on    = 1'b1;
  int          items_sent = 0;

  // Receiver stall state
  int unsigned stall_left      = 0;
  int unsigned stall_mode      = 0;
  int unsigned stall_mode_left = 0;

  int unsigned quiet_cycles = 0;

  // Random phase settings
  int unsigned settle;
  int unsigned avg;
  int unsigned dz;
  int unsigned amp;
  int unsigned style;
  int unsigned pick;
  int unsigned count;
  int          noise;
  bit          late;
  logic [NUM_AXES-1:0][SAMPLE_W-1:0] bias;
  logic [NUM_AXES-1:0][SAMPLE_W-1:0] sample;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  accel_offset_autocalibrator_top i_dut (.*);

  acal_checker i_checker (.*);

  // Output back-pressure: modes change now and then, mode 0 starts no new stalls.
  always @(negedge clk) begin
    if (stall_mode_left == 0) begin
      stall_mode      = $urandom_range(0, 2);
      stall_mode_left = $urandom_range(50, 400);
    end else begin
      stall_mode_left--;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (stall_mode != 0 && $urandom_range(0, 9) < stall_mode * 3) begin
      stall_left = $urandom_range(0, 7);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog on cycles with no item moving on either channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Lower valid for a number of cycles.
  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
  endtask

  // Offer one sample and wait until it is accepted; bursts are separated by gaps when gaps_on is set.
  task automatic push_sample(input logic [SAMPLE_W-1:0] x, y, z);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        idle_cycles($urandom_range(1, 6));
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {z, y, x};
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop sending and wait until every expected result item has arrived.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_reg(input reg_idx_t idx, input int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= 15'(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Reset values: a few extreme samples, all inside the settle window.
    push_sample(16'h7FFF, 16'h8000, 16'h0000);
    push_sample(16'h8000, 16'h7FFF, 16'hFFFF);
    push_sample(16'h0000, 16'hFFFF, 16'h7FFF);
    push_sample(16'hFFFF, 16'h0000, 16'h8000);
    push_sample(16'h5555, 16'hAAAA, 16'h0F0F);
    push_sample(16'hAAAA, 16'h5555, 16'hF0F0);
    drain_results();

    // Zero average count acts as one: every sample closes a pass.
    write_reg(REG_SETTLE, 0);
    write_reg(REG_AVERAGE, 0);
    write_reg(REG_DEADZONE, 0);
    push_sample(16'h8000, 16'h8000, 16'h8000);
    push_sample(16'h0064, 16'hFF38, 16'h7FFF);
    push_sample(16'h0064, 16'h3039, 16'h0001);
    push_sample(16'h8000, 16'h0000, 16'h0007);
    push_sample(16'h7FFF, 16'h7FFF, 16'h8000);
    drain_results();

    // Widest deadzone, but a mean of -32768 on every axis is still out of it.
    write_reg(REG_DEADZONE, 32767);
    push_sample(16'hFFFF, 16'hFFFF, 16'h0000);
    drain_results();

    // Shrinking the average mid-pass makes the mean saturate both ways.
    write_reg(REG_DEADZONE, 0);
    write_reg(REG_AVERAGE, MAX_AVERAGE);
    repeat (3) push_sample(16'h7FFE, 16'h7FFE, 16'h8000);
    drain_results();
    write_reg(REG_AVERAGE, 1);
    push_sample(16'h7FFE, 16'h7FFE, 16'h8000);
    drain_results();

    // Oversized average count is capped, then the pass is closed early.
    write_reg(REG_SETTLE, 3);
    write_reg(REG_AVERAGE, 2047);
    push_sample(16'h0001, 16'h0002, 16'h0003);
    push_sample(16'hFFFC, 16'hFFFB, 16'hFFFA);
    push_sample(16'h1234, 16'hABCD, 16'h5A5A);
    push_sample(16'h7FFF, 16'h0000, 16'h8000);
    push_sample(16'h8000, 16'hFFFF, 16'h7FFF);
    drain_results();
    write_reg(REG_SETTLE, 0);
    write_reg(REG_AVERAGE, 2);
    push_sample(16'h4321, 16'h8765, 16'h0F0F);
    items_sent = 22;

    // Random phases: mostly a steady bias with noise, some pure noise and bias jumps.
    // Early phases keep the deadzone tight so calibration stays open.
    while (items_sent < ITEM_TARGET) begin
      drain_results();
      late = (items_sent >= LATE_START);

      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        settle = $urandom_range(0, 12);
      end else if (pick < 8) begin
        settle = $urandom_range(13, 60);
      end else if (pick == 8) begin
        settle = 0;
      end else begin
        settle = 1023;
      end

      pick = $urandom_range(0, 15);
      if (pick < 8) begin
        avg = $urandom_range(1, 16);
      end else if (pick < 12) begin
        avg = $urandom_range(17, 64);
      end else if (pick == 12) begin
        avg = 0;
      end else if (pick == 13) begin
        avg = MAX_AVERAGE;
      end else if (pick == 14) begin
        avg = 2047;
      end else begin
        avg = $urandom_range(MAX_AVERAGE + 1, 2046);
      end

      if (!late) begin
        dz  = $urandom_range(0, 2);
        amp = $urandom_range(256, 8000);
      end else begin
        pick = $urandom_range(0, 3);
        case (pick)
          0:       dz = 0;
          1:       dz = 32767;
          2:       dz = $urandom_range(0, 40);
          default: dz = $urandom_range(41, 2000);
        endcase
        pick = $urandom_range(0, 3);
        case (pick)
          0:       amp = 0;
          1:       amp = $urandom_range(1, 8);
          2:       amp = $urandom_range(9, 300);
          default: amp = $urandom_range(301, 4000);
        endcase
      end

      write_reg(REG_SETTLE, settle);
      write_reg(REG_AVERAGE, avg);
      write_reg(REG_DEADZONE, dz);

      style   = $urandom_range(0, 9);
      gaps_on = ($urandom_range(0, 3) != 0);
      bias    = {16'($urandom), 16'($urandom), 16'($urandom)};
      count   = $urandom_range(40, 160);
      repeat (count) begin
        // Broken sequences: the bias jumps now and then.
        if (style == 9 && $urandom_range(0, 7) == 0) begin
          bias = {16'($urandom), 16'($urandom), 16'($urandom)};
        end
        for (int k = 0; k < NUM_AXES; k++) begin
          if (style >= 7 && style <= 8) begin
            sample[k] = 16'($urandom);
          end else begin
            noise     = int'($urandom_range(0, 2 * amp)) - int'(amp);
            sample[k] = bias[k] + noise[SAMPLE_W-1:0];
          end
        end
        push_sample(sample[0], sample[1], sample[2]);
        items_sent++;
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
